// ===== src/sfpr_pkg.sv =====
// ----------------------------------------------------------------------------
// sfpr_pkg
// Shared types, codes and the crc-8 byte update for the framed packet
// receiver.
// ----------------------------------------------------------------------------
`default_nettype none

package sfpr_pkg;

    // default largest packet length (exclusive)
    localparam int MAX_PACKET_DEF = 512;

    // field widths
    localparam int BYTE_W   = 8;
    localparam int OFFSET_W = 9;
    localparam int LEN_W    = 16;
    localparam int COUNT_W  = 16;
    localparam int CFG_IDX_W = 3;

    // shortest legal packet length
    localparam logic [LEN_W-1:0] MIN_LENGTH = 16'd10;

    // reflected polynomial of crc-8 maxim
    localparam logic [7:0] CRC_POLY = 8'h8C;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_OWN_ADDRESS = 3'd0,
        CFG_OWN_TYPE    = 3'd1,
        CFG_MASTER_TYPE = 3'd2,
        CFG_GAP_TICKS   = 3'd3,
        CFG_SYNC_CODE   = 3'd4,
        CFG_START_CODE  = 3'd5,
        CFG_END_CODE    = 3'd6
    } cfg_index_t;

    // end of packet status codes
    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_HDR_CRC  = 3'd1,
        ST_LENGTH   = 3'd2,
        ST_BODY_CRC = 3'd3,
        ST_NO_END   = 3'd4,
        ST_NOT_ADDR = 3'd5,
        ST_TIMEOUT  = 3'd6,
        ST_NO_START = 3'd7
    } status_t;

    // result kinds
    localparam logic KIND_CMD    = 1'b0;
    localparam logic KIND_STATUS = 1'b1;

    // input kinds
    localparam logic FUNC_BYTE = 1'b0;
    localparam logic FUNC_TICK = 1'b1;

    // configuration register set
    typedef struct packed {
        logic [7:0] own_address;
        logic [7:0] own_type;
        logic [7:0] master_type;
        logic [7:0] gap_ticks;
        logic [7:0] sync_code;
        logic [7:0] start_code;
        logic [7:0] end_code;
    } cfg_t;

    // one input request
    typedef struct packed {
        logic       func;
        logic [7:0] rx_byte;
    } item_t;

    // one result request
    typedef struct packed {
        logic                  kind;
        logic [7:0]            data_byte;
        logic [OFFSET_W-1:0]   byte_offset;
        status_t               status;
        logic [7:0]            sequence_res;
        logic [7:0]            source_address;
        logic [COUNT_W-1:0]    fault_count;
        logic [COUNT_W-1:0]    good_count;
    } res_t;

    // crc-8 maxim update by one byte, lsb first
    function automatic logic [7:0] crc_step(input logic [7:0] c, input logic [7:0] b);
        logic [7:0] r;
        r = c ^ b;
        for (int k = 0; k < 8; k++)
        begin
            if (r[0])
            begin
                r = (r >> 1) ^ CRC_POLY;
            end
            else
            begin
                r = r >> 1;
            end
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== src/sync_framed_packet_receiver.sv =====
// Path: an accepted request passes the input register and then the result
//   register before its result is presented on m_tvalid.
// Throughput: one request per cycle while no result is held up by a full
//   result register, with the crc update and framing decision combinational.
// Reset: rst_n clears the framing state, counters, stage flags and the
//   configuration registers to their defaults at once; no clearing pass.
// ----------------------------------------------------------------------------
// sync_framed_packet_receiver
// Framed packet receiver with crc-8 maxim header and body checks, command
// byte streaming and per-packet status results.
// ----------------------------------------------------------------------------
`default_nettype none

module sync_framed_packet_receiver
    import sfpr_pkg::*;
#(
    parameter int MAX_PACKET = MAX_PACKET_DEF
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    // configuration write port
    input  wire logic                 cfg_we,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [7:0]           cfg_data,
    // input stream
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire logic [7:0]           s_tdata,   // rx_byte[7:0]
    input  wire logic                 s_tuser,   // func[0]
    // result stream
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    // data_byte[7:0], byte_offset[16:8], status[19:17], sequence_res[27:20],
    // source_address[35:28], fault_count[51:36], good_count[67:52], zero[71:68]
    output logic [71:0]               m_tdata,
    output logic                      m_tuser    // kind[0]
);

    cfg_t  cfg;
    item_t s_item;
    item_t item;
    logic  item_valid;
    logic  adv;
    logic  res_valid;
    logic  out_free;
    res_t  res_c;
    res_t  res_q;

    assign s_item.func    = s_tuser;
    assign s_item.rx_byte = s_tdata;

    // configuration registers
    sfpr_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // input register
    sfpr_in_stage u_in (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_item     (s_item),
        .adv        (adv),
        .item_valid (item_valid),
        .item       (item)
    );

    // framing logic
    sfpr_core #(
        .MAX_PACKET (MAX_PACKET)
    ) u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .item_valid (item_valid),
        .item       (item),
        .out_free   (out_free),
        .adv        (adv),
        .res_valid  (res_valid),
        .res        (res_c)
    );

    // result register
    sfpr_out_stage u_out (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (res_valid),
        .res_in   (res_c),
        .out_free (out_free),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .res_out  (res_q)
    );

    // result packing
    assign m_tuser = res_q.kind;
    assign m_tdata = {4'd0, res_q.good_count, res_q.fault_count, res_q.source_address,
                      res_q.sequence_res, res_q.status, res_q.byte_offset,
                      res_q.data_byte};

    // a result is only loaded when the result register can take it
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> (!m_tvalid || m_tready))
        else $error("result loaded into a stalled result register");

    // a loaded result shows up on the next cycle
    a_load_shows: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |=> m_tvalid)
        else $error("loaded result not presented");

    // an accepted request sits in the input register on the next cycle
    a_in_held: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> item_valid)
        else $error("accepted request lost");

    // command bytes carry an ok status and lie past the header
    a_cmd_fields: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser == KIND_CMD) |->
        (res_q.status == ST_OK && res_q.byte_offset >= OFFSET_W'(7)))
        else $error("malformed command byte result");

endmodule

`default_nettype wire

// ===== src/sfpr_cfg.sv =====
// ----------------------------------------------------------------------------
// sfpr_cfg
// Configuration register bank, written through a plain write port.
// ----------------------------------------------------------------------------
`default_nettype none

module sfpr_cfg
    import sfpr_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cfg_we,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [7:0]           cfg_data,
    output cfg_t                      cfg
);

    cfg_t cfg_reg;

    // register writes, indexes past the list are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.own_address <= 8'd0;
            cfg_reg.own_type    <= 8'd0;
            cfg_reg.master_type <= 8'd0;
            cfg_reg.gap_ticks   <= 8'd15;
            cfg_reg.sync_code   <= 8'd22;
            cfg_reg.start_code  <= 8'd1;
            cfg_reg.end_code    <= 8'd4;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_OWN_ADDRESS: cfg_reg.own_address <= cfg_data;
                CFG_OWN_TYPE:    cfg_reg.own_type    <= cfg_data;
                CFG_MASTER_TYPE: cfg_reg.master_type <= cfg_data;
                CFG_GAP_TICKS:   cfg_reg.gap_ticks   <= cfg_data;
                CFG_SYNC_CODE:   cfg_reg.sync_code   <= cfg_data;
                CFG_START_CODE:  cfg_reg.start_code  <= cfg_data;
                CFG_END_CODE:    cfg_reg.end_code    <= cfg_data;
                default:         ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

// ===== src/sfpr_in_stage.sv =====
// ----------------------------------------------------------------------------
// sfpr_in_stage
// Input register: holds one request until the receive logic takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module sfpr_in_stage
    import sfpr_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic s_tvalid,
    output logic      s_tready,
    input  wire item_t s_item,
    input  wire logic adv,
    output logic      item_valid,
    output item_t     item
);

    logic  valid_reg;
    logic  valid_next;
    item_t item_reg;
    logic  take;

    // free when empty or when the held request moves on this cycle
    assign s_tready = !valid_reg || adv;
    assign take     = s_tvalid && s_tready;

    always_comb
    begin
        valid_next = valid_reg;
        if (take)
        begin
            valid_next = 1'b1;
        end
        else if (adv)
        begin
            valid_next = 1'b0;
        end
    end

    // occupancy flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            item_reg <= s_item;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

`default_nettype wire

// ===== src/sfpr_core.sv =====
// ----------------------------------------------------------------------------
// sfpr_core
// Packet framing state machine: sync hunt, header and body crc checks,
// address match, command byte streaming and packet counters.
// ----------------------------------------------------------------------------
`default_nettype none

module sfpr_core
    import sfpr_pkg::*;
#(
    parameter int MAX_PACKET = MAX_PACKET_DEF
)
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire cfg_t  cfg,
    input  wire logic  item_valid,
    input  wire item_t item,
    input  wire logic  out_free,
    output logic       adv,
    output logic       res_valid,
    output res_t       res
);

    localparam int IDX_W = $clog2(MAX_PACKET);

    typedef enum logic [5:0] {
        PH_HUNT   = 6'b000001,
        PH_SYNC   = 6'b000010,
        PH_HEAD   = 6'b000100,
        PH_BODY   = 6'b001000,
        PH_ENDOK  = 6'b010000,
        PH_ENDBAD = 6'b100000
    } phase_t;

    phase_t             phase_reg, phase_next;
    logic [IDX_W-1:0]   idx_reg, idx_next;
    logic [LEN_W-1:0]   len_reg, len_next;
    logic [7:0]         crc_reg, crc_next;
    logic [7:0]         dst_type_reg, dst_type_next;
    logic [7:0]         dst_addr_reg, dst_addr_next;
    logic [7:0]         src_type_reg, src_type_next;
    logic [7:0]         src_addr_reg, src_addr_next;
    logic [7:0]         seq_reg, seq_next;
    logic [7:0]         idle_reg, idle_next;
    logic [COUNT_W-1:0] fault_reg, fault_next;
    logic [COUNT_W-1:0] good_reg, good_next;

    logic               emit_cmd;
    logic               finish;
    status_t            st;
    logic [7:0]         idle_inc;
    logic [7:0]         crc_upd;
    logic [IDX_W-1:0]   idx_inc;
    logic [LEN_W:0]     idx_ext;
    logic [7:0]         b;

    assign b       = item.rx_byte;
    assign crc_upd = crc_step(crc_reg, b);
    assign idx_inc = IDX_W'(idx_reg + 1'b1);
    assign idx_ext = {1'b0, LEN_W'(idx_reg)};
    assign idle_inc = (idle_reg == 8'hFF) ? idle_reg : 8'(idle_reg + 1'b1);

    // next state for the held request
    always_comb
    begin
        phase_next    = phase_reg;
        idx_next      = idx_reg;
        len_next      = len_reg;
        crc_next      = crc_reg;
        dst_type_next = dst_type_reg;
        dst_addr_next = dst_addr_reg;
        src_type_next = src_type_reg;
        src_addr_next = src_addr_reg;
        seq_next      = seq_reg;
        idle_next     = idle_reg;
        fault_next    = fault_reg;
        good_next     = good_reg;
        emit_cmd      = 1'b0;
        finish        = 1'b0;
        st            = ST_OK;

        if (item.func == FUNC_TICK)
        begin
            // gap timer, idle while hunting
            if (phase_reg != PH_HUNT)
            begin
                idle_next = idle_inc;
                if (idle_inc >= cfg.gap_ticks)
                begin
                    finish = 1'b1;
                    st     = ST_TIMEOUT;
                end
            end
        end
        else
        begin
            idle_next = 8'd0;
            case (phase_reg)
                PH_HUNT:
                begin
                    if (b == cfg.sync_code)
                    begin
                        phase_next    = PH_SYNC;
                        dst_type_next = 8'd0;
                        dst_addr_next = 8'd0;
                        src_type_next = 8'd0;
                        src_addr_next = 8'd0;
                        seq_next      = 8'd0;
                        len_next      = '0;
                    end
                end
                PH_SYNC:
                begin
                    if (b == cfg.sync_code)
                    begin
                        phase_next = PH_SYNC;
                    end
                    else if (b == cfg.start_code)
                    begin
                        phase_next = PH_HEAD;
                        idx_next   = '0;
                        crc_next   = 8'd0;
                    end
                    else
                    begin
                        finish = 1'b1;
                        st     = ST_NO_START;
                    end
                end
                PH_HEAD:
                begin
                    if (idx_reg == IDX_W'(6))
                    begin
                        // header crc byte
                        if (crc_reg != b)
                        begin
                            finish = 1'b1;
                            st     = ST_HDR_CRC;
                        end
                        else if (len_reg < MIN_LENGTH ||
                                 {1'b0, len_reg} >= (LEN_W+1)'(MAX_PACKET))
                        begin
                            finish = 1'b1;
                            st     = ST_LENGTH;
                        end
                        else
                        begin
                            crc_next   = crc_upd;
                            idx_next   = IDX_W'(7);
                            phase_next = PH_BODY;
                        end
                    end
                    else
                    begin
                        case (idx_reg[2:0])
                            3'd0:    dst_type_next = b;
                            3'd1:    dst_addr_next = b;
                            3'd2:    src_type_next = b;
                            3'd3:    src_addr_next = b;
                            3'd4:    len_next = {len_reg[15:8], b};
                            3'd5:    len_next = {b, len_reg[7:0]};
                            default: ;
                        endcase
                        crc_next = crc_upd;
                        idx_next = idx_inc;
                    end
                end
                PH_BODY:
                begin
                    idx_next = idx_inc;
                    if (idx_ext + 17'd2 == {1'b0, len_reg})
                    begin
                        // body crc byte
                        phase_next = (b == crc_reg) ? PH_ENDOK : PH_ENDBAD;
                    end
                    else
                    begin
                        crc_next = crc_upd;
                        if (idx_ext + 17'd3 == {1'b0, len_reg})
                        begin
                            seq_next = b;
                        end
                        else
                        begin
                            emit_cmd = 1'b1;
                        end
                    end
                end
                PH_ENDOK:
                begin
                    finish = 1'b1;
                    if (b != cfg.end_code)
                    begin
                        st = ST_NO_END;
                    end
                    else if (src_type_reg != cfg.master_type)
                    begin
                        st = ST_NOT_ADDR;
                    end
                    else if (dst_addr_reg != cfg.own_address ||
                             dst_type_reg != cfg.own_type)
                    begin
                        st = ST_NOT_ADDR;
                    end
                    else
                    begin
                        st = ST_OK;
                    end
                end
                PH_ENDBAD:
                begin
                    finish = 1'b1;
                    st     = ST_BODY_CRC;
                end
                default:
                begin
                    phase_next = PH_HUNT;
                end
            endcase
        end

        // end of attempt
        if (finish)
        begin
            phase_next = PH_HUNT;
            idle_next  = 8'd0;
            if (st == ST_OK)
            begin
                good_next = COUNT_W'(good_reg + 1'b1);
            end
            else
            begin
                fault_next = COUNT_W'(fault_reg + 1'b1);
            end
        end
    end

    // handshake towards input and output stages
    assign adv       = item_valid && (out_free || !(finish || emit_cmd));
    assign res_valid = adv && (finish || emit_cmd);

    // result built from the updated state
    always_comb
    begin
        res.kind           = finish ? KIND_STATUS : KIND_CMD;
        res.data_byte      = finish ? 8'd0 : b;
        res.byte_offset    = finish ? '0 : OFFSET_W'(idx_reg);
        res.status         = finish ? st : ST_OK;
        res.sequence_res   = seq_next;
        res.source_address = src_addr_next;
        res.fault_count    = fault_next;
        res.good_count     = good_next;
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_HUNT;
            idx_reg      <= '0;
            len_reg      <= '0;
            crc_reg      <= 8'd0;
            dst_type_reg <= 8'd0;
            dst_addr_reg <= 8'd0;
            src_type_reg <= 8'd0;
            src_addr_reg <= 8'd0;
            seq_reg      <= 8'd0;
            idle_reg     <= 8'd0;
            fault_reg    <= '0;
            good_reg     <= '0;
        end
        else if (adv)
        begin
            phase_reg    <= phase_next;
            idx_reg      <= idx_next;
            len_reg      <= len_next;
            crc_reg      <= crc_next;
            dst_type_reg <= dst_type_next;
            dst_addr_reg <= dst_addr_next;
            src_type_reg <= src_type_next;
            src_addr_reg <= src_addr_next;
            seq_reg      <= seq_next;
            idle_reg     <= idle_next;
            fault_reg    <= fault_next;
            good_reg     <= good_next;
        end
    end

endmodule

`default_nettype wire

// ===== src/sfpr_out_stage.sv =====
// ----------------------------------------------------------------------------
// sfpr_out_stage
// Result register: holds one result request until the sink takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module sfpr_out_stage
    import sfpr_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic load,
    input  wire res_t res_in,
    output logic      out_free,
    output logic      m_tvalid,
    input  wire logic m_tready,
    output res_t      res_out
);

    logic valid_reg;
    logic valid_next;
    res_t res_reg;

    assign out_free = !valid_reg || m_tready;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            valid_next = 1'b0;
        end
    end

    // occupancy flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            res_reg <= res_in;
        end
    end

    assign m_tvalid = valid_reg;
    assign res_out  = res_reg;

endmodule

`default_nettype wire

// ===== tb/sync_framed_packet_receiver_tb.sv =====
// ----------------------------------------------------------------------------
// sync_framed_packet_receiver_tb
// Self-checking bench for the framed packet receiver. A short directed table
// runs first, then random frames, broken frames, noise and timer ticks over
// several register settings. Every result request is checked in order
// against the directed table or an in-bench model of framing, crc and counters.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module sync_framed_packet_receiver_tb;
    import sfpr_pkg::*;

    localparam int PHASES          = 6;
    localparam int ITEMS_PER_PHASE = 120;
    localparam int CYCLE_LIMIT     = 200000;
    localparam int SETTLE_CYCLES   = 4;
    localparam int MAX_REPORTS     = 10;
    localparam int LONGEST_FRAME   = MAX_PACKET_DEF - 1;
    localparam res_t NO_RESULT     = '0;

    // framing phases of the in-bench model
    typedef enum logic [2:0] {
        RX_HUNT,
        RX_SYNC,
        RX_HEAD,
        RX_BODY,
        RX_END_GOOD,
        RX_END_BAD
    } rx_phase_e;

    // one row of the directed table
    typedef struct {
        logic       func;
        logic [7:0] value;
        bit         crc_byte;   // send the model's running crc instead of value
        bit         typed;      // expectation written into the table
        bit         typed_has;
        res_t       typed_res;
    } plan_row_t;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [7:0]  cfg_data  = 8'h00;
    logic        s_tvalid  = 1'b0;
    logic [7:0]  s_tdata   = 8'h00;
    logic        s_tuser   = 1'b0;
    logic        m_tready  = 1'b0;
    wire         s_tready;
    wire         m_tvalid;
    wire  [71:0] m_tdata;
    wire         m_tuser;

    // model state
    cfg_t        rx_cfg = '{own_address: 8'd0, own_type: 8'd0, master_type: 8'd0,
                            gap_ticks: 8'd15, sync_code: 8'd22, start_code: 8'd1,
                            end_code: 8'd4};
    rx_phase_e   rx_phase = RX_HUNT;
    logic [15:0] rx_index = '0;
    logic [15:0] rx_len   = '0;
    logic [7:0]  rx_crc   = '0;
    logic [31:0] rx_hdr   = '0;
    logic [7:0]  rx_seq   = '0;
    logic [7:0]  rx_idle  = '0;
    logic [15:0] rx_faults = '0;
    logic [15:0] rx_goods  = '0;

    res_t        pending_results[$];
    int          mismatch_count = 0;
    int          counted_items  = 0;
    int          cycle_count    = 0;
    int          send_idle_pct  = 0;
    int          recv_idle_pct  = 0;

    sync_framed_packet_receiver DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    // clock
    always #1 clk = ~clk;

    // run limit
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // crc-8 maxim, bit-serial form, data lsb first
    function automatic logic [7:0] crc8_update(input logic [7:0] c, input logic [7:0] b);
        logic fb;
        for (int k = 0; k < 8; k++)
        begin
            fb = c[0] ^ b[k];
            c  = c >> 1;
            if (fb)
            begin
                c = c ^ 8'h8C;
            end
        end
        return c;
    endfunction

    function automatic res_t mk_res(input logic kind, input logic [7:0] data,
                                    input logic [8:0] off, input status_t st,
                                    input logic [7:0] seq, input logic [7:0] src,
                                    input logic [15:0] faults, input logic [15:0] goods);
        res_t r;
        r.kind           = kind;
        r.data_byte      = data;
        r.byte_offset    = off;
        r.status         = st;
        r.sequence_res   = seq;
        r.source_address = src;
        r.fault_count    = faults;
        r.good_count     = goods;
        return r;
    endfunction

    function automatic plan_row_t plan_row(input logic f, input logic [7:0] v,
                                           input bit use_crc, input bit typed,
                                           input bit has, input res_t r);
        plan_row_t row;
        row.func      = f;
        row.value     = v;
        row.crc_byte  = use_crc;
        row.typed     = typed;
        row.typed_has = has;
        row.typed_res = r;
        return row;
    endfunction

    // end of a packet attempt: count it and build the status result
    task automatic close_packet(input status_t st, output res_t r);
        if (st == ST_OK)
        begin
            rx_goods = rx_goods + 16'd1;
        end
        else
        begin
            rx_faults = rx_faults + 16'd1;
        end
        rx_phase = RX_HUNT;
        rx_idle  = 8'd0;
        r = mk_res(KIND_STATUS, 8'h00, 9'd0, st, rx_seq, rx_hdr[31:24], rx_faults, rx_goods);
    endtask

    // model of one accepted request
    task automatic frame_predict(input logic f, input logic [7:0] b,
                                 output bit got, output res_t r, output bit ign);
        logic [15:0] i;
        got = 1'b0;
        ign = 1'b0;
        r   = NO_RESULT;
        i   = rx_index;
        if (f == FUNC_TICK)
        begin
            if (rx_phase == RX_HUNT)
            begin
                ign = 1'b1;
            end
            else
            begin
                if (rx_idle != 8'hFF)
                begin
                    rx_idle = rx_idle + 8'd1;
                end
                if (rx_idle >= rx_cfg.gap_ticks)
                begin
                    close_packet(ST_TIMEOUT, r);
                    got = 1'b1;
                end
            end
        end
        else
        begin
            rx_idle = 8'd0;
            case (rx_phase)
                RX_HUNT:
                begin
                    if (b == rx_cfg.sync_code)
                    begin
                        rx_phase = RX_SYNC;
                        rx_hdr   = '0;
                        rx_seq   = '0;
                        rx_len   = '0;
                    end
                    else
                    begin
                        ign = 1'b1;
                    end
                end
                RX_SYNC:
                begin
                    if (b == rx_cfg.sync_code)
                    begin
                        // repeated sync, keep waiting for the start code
                    end
                    else if (b == rx_cfg.start_code)
                    begin
                        rx_phase = RX_HEAD;
                        rx_index = '0;
                        rx_crc   = '0;
                    end
                    else
                    begin
                        close_packet(ST_NO_START, r);
                        got = 1'b1;
                    end
                end
                RX_HEAD:
                begin
                    if (i < 16'd6)
                    begin
                        if (i < 16'd4)
                        begin
                            rx_hdr[{i[1:0], 3'b000} +: 8] = b;
                        end
                        else if (i == 16'd4)
                        begin
                            rx_len[7:0] = b;
                        end
                        else
                        begin
                            rx_len[15:8] = b;
                        end
                        rx_crc   = crc8_update(rx_crc, b);
                        rx_index = i + 16'd1;
                    end
                    else if (rx_crc != b)
                    begin
                        close_packet(ST_HDR_CRC, r);
                        got = 1'b1;
                    end
                    else if (rx_len < MIN_LENGTH || rx_len >= MAX_PACKET_DEF)
                    begin
                        close_packet(ST_LENGTH, r);
                        got = 1'b1;
                    end
                    else
                    begin
                        rx_crc   = crc8_update(rx_crc, b);
                        rx_index = 16'd7;
                        rx_phase = RX_BODY;
                    end
                end
                RX_BODY:
                begin
                    if (i + 2 == rx_len)
                    begin
                        rx_phase = (b == rx_crc) ? RX_END_GOOD : RX_END_BAD;
                        rx_index = i + 16'd1;
                    end
                    else
                    begin
                        rx_crc   = crc8_update(rx_crc, b);
                        rx_index = i + 16'd1;
                        if (i + 3 == rx_len)
                        begin
                            rx_seq = b;
                        end
                        else
                        begin
                            r = mk_res(KIND_CMD, b, i[8:0], ST_OK, rx_seq, rx_hdr[31:24],
                                       rx_faults, rx_goods);
                            got = 1'b1;
                        end
                    end
                end
                RX_END_GOOD, RX_END_BAD:
                begin
                    got = 1'b1;
                    // body crc, end code, source type, then own address and type
                    if (rx_phase == RX_END_BAD)
                    begin
                        close_packet(ST_BODY_CRC, r);
                    end
                    else if (b != rx_cfg.end_code)
                    begin
                        close_packet(ST_NO_END, r);
                    end
                    else if (rx_hdr[23:16] != rx_cfg.master_type)
                    begin
                        close_packet(ST_NOT_ADDR, r);
                    end
                    else if (rx_hdr[15:8] != rx_cfg.own_address
                             || rx_hdr[7:0] != rx_cfg.own_type)
                    begin
                        close_packet(ST_NOT_ADDR, r);
                    end
                    else
                    begin
                        close_packet(ST_OK, r);
                    end
                end
                default:
                begin
                    rx_phase = RX_HUNT;
                end
            endcase
        end
    endtask

    task automatic note_failure(input string msg);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
        begin
            $display("[%0t] %s", $time, msg);
        end
    endtask

    // drive one request, wait for it to be taken, then predict its result
    task automatic push_request(input logic f, input logic [7:0] v, input bit use_crc,
                                input bit typed, input bit typed_has, input res_t typed_res);
        logic [7:0] b;
        bit         got;
        bit         ign;
        res_t       r;
        b = use_crc ? rx_crc : v;
        if ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < send_idle_pct);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= f;
        s_tdata  <= b;
        do
            @(posedge clk);
        while (!s_tready);
        frame_predict(f, b, got, r, ign);
        if (typed)
        begin
            got = typed_has;
            r   = typed_res;
        end
        if (got)
        begin
            pending_results.push_back(r);
        end
        if (!ign)
        begin
            counted_items++;
        end
    endtask

    task automatic send_item(input logic f, input logic [7:0] b);
        push_request(f, b, 1'b0, 1'b0, 1'b0, NO_RESULT);
    endtask

    // sender holds off until every expected result is out
    task automatic drain_results();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending_results.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input cfg_index_t idx, input logic [7:0] v);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= v;
        @(posedge clk);
        case (idx)
            CFG_OWN_ADDRESS: rx_cfg.own_address = v;
            CFG_OWN_TYPE:    rx_cfg.own_type    = v;
            CFG_MASTER_TYPE: rx_cfg.master_type = v;
            CFG_GAP_TICKS:   rx_cfg.gap_ticks   = v;
            CFG_SYNC_CODE:   rx_cfg.sync_code   = v;
            CFG_START_CODE:  rx_cfg.start_code  = v;
            CFG_END_CODE:    rx_cfg.end_code    = v;
            default:         ;
        endcase
    endtask

    task automatic apply_config(input cfg_t c);
        write_reg(CFG_OWN_ADDRESS, c.own_address);
        write_reg(CFG_OWN_TYPE, c.own_type);
        write_reg(CFG_MASTER_TYPE, c.master_type);
        write_reg(CFG_GAP_TICKS, c.gap_ticks);
        write_reg(CFG_SYNC_CODE, c.sync_code);
        write_reg(CFG_START_CODE, c.start_code);
        write_reg(CFG_END_CODE, c.end_code);
        cfg_we <= 1'b0;
    endtask

    // register settings per phase: both extremes, then random ones
    function automatic cfg_t phase_config(input int p);
        cfg_t c;
        case (p)
            1: c = '{own_address: 8'h00, own_type: 8'h00, master_type: 8'h00,
                     gap_ticks: 8'd1, sync_code: 8'h00, start_code: 8'hFF,
                     end_code: 8'h00};
            2: c = '{own_address: 8'hFF, own_type: 8'hFF, master_type: 8'hFF,
                     gap_ticks: 8'd255, sync_code: 8'hFF, start_code: 8'h00,
                     end_code: 8'hFF};
            default:
            begin
                c.own_address = 8'($urandom);
                c.own_type    = 8'($urandom);
                c.master_type = 8'($urandom);
                c.gap_ticks   = 8'($urandom_range(2, 40));
                c.sync_code   = 8'($urandom);
                do
                    c.start_code = 8'($urandom);
                while (c.start_code == c.sync_code);
                c.end_code    = 8'($urandom);
            end
        endcase
        return c;
    endfunction

    // short burst of ticks, codes and random bytes
    task automatic send_noise();
        int n;
        int r;
        n = $urandom_range(1, 8);
        repeat (n)
        begin
            r = $urandom_range(99);
            if (r < 25)
            begin
                send_item(FUNC_TICK, 8'($urandom));
            end
            else if (r < 45)
            begin
                send_item(FUNC_BYTE, rx_cfg.sync_code);
            end
            else if (r < 55)
            begin
                send_item(FUNC_BYTE, rx_cfg.start_code);
            end
            else
            begin
                send_item(FUNC_BYTE, 8'($urandom));
            end
        end
    endtask

    // one frame, mostly well formed, with ticks and the odd fault mixed in
    task automatic send_frame(input int forced_len);
        logic [7:0]  fb[$];
        logic [7:0]  crc;
        logic [7:0]  cb;
        logic [15:0] len;
        int          r;
        int          k;
        int          abort_at;
        // get back to hunting first
        while (rx_phase != RX_HUNT)
        begin
            send_item(FUNC_BYTE, 8'($urandom));
        end
        repeat ($urandom_range(1, 3)) fb.push_back(rx_cfg.sync_code);
        fb.push_back(rx_cfg.start_code);
        fb.push_back(($urandom_range(9) != 0) ? rx_cfg.own_type : 8'($urandom));
        fb.push_back(($urandom_range(9) != 0) ? rx_cfg.own_address : 8'($urandom));
        fb.push_back(($urandom_range(9) != 0) ? rx_cfg.master_type : 8'($urandom));
        fb.push_back(8'($urandom));
        r = $urandom_range(99);
        if (forced_len > 0)
        begin
            len = 16'(forced_len);
        end
        else if (r < 5)
        begin
            len = 16'($urandom_range(0, 9));
        end
        else if (r < 8)
        begin
            len = 16'(MAX_PACKET_DEF);
        end
        else if (r < 13)
        begin
            len = 16'($urandom_range(MAX_PACKET_DEF + 1, 65535));
        end
        else if (r < 20)
        begin
            len = 16'($urandom_range(41, 300));
        end
        else
        begin
            len = 16'($urandom_range(10, 40));
        end
        fb.push_back(len[7:0]);
        fb.push_back(len[15:8]);
        crc = 8'h00;
        for (k = fb.size() - 6; k < fb.size(); k++)
        begin
            crc = crc8_update(crc, fb[k]);
        end
        cb = ($urandom_range(19) != 0) ? crc : crc ^ 8'($urandom_range(1, 255));
        fb.push_back(cb);
        // body only where the header gets through
        if (cb == crc && len >= MIN_LENGTH && len < MAX_PACKET_DEF)
        begin
            crc = crc8_update(crc, cb);
            for (k = 7; k < int'(len) - 2; k++)
            begin
                cb = 8'($urandom);
                fb.push_back(cb);
                crc = crc8_update(crc, cb);
            end
            fb.push_back(($urandom_range(19) != 0) ? crc : crc ^ 8'($urandom_range(1, 255)));
            fb.push_back(($urandom_range(19) != 0) ? rx_cfg.end_code : 8'($urandom));
        end
        abort_at = ($urandom_range(99) < 3) ? $urandom_range(0, fb.size() - 1) : -1;
        for (k = 0; k < fb.size(); k++)
        begin
            if (k == abort_at)
            begin
                repeat (rx_cfg.gap_ticks) send_item(FUNC_TICK, 8'($urandom));
            end
            else if (rx_cfg.gap_ticks > 8'd1 && $urandom_range(99) < 8)
            begin
                repeat ($urandom_range(1, (rx_cfg.gap_ticks > 8'd4) ? 3 : rx_cfg.gap_ticks - 1))
                    send_item(FUNC_TICK, 8'($urandom));
            end
            send_item(FUNC_BYTE, fb[k]);
        end
    endtask

    // result side: random stalls, in-order field compare
    always @(posedge clk)
    begin
        res_t want_r;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_results.size() == 0)
            begin
                note_failure($sformatf("unexpected result: kind %0d tdata %h", m_tuser, m_tdata));
            end
            else
            begin
                want_r = pending_results.pop_front();
                if (m_tuser !== want_r.kind
                    || m_tdata[7:0] !== want_r.data_byte
                    || m_tdata[16:8] !== want_r.byte_offset
                    || m_tdata[19:17] !== want_r.status
                    || m_tdata[27:20] !== want_r.sequence_res
                    || m_tdata[35:28] !== want_r.source_address
                    || m_tdata[51:36] !== want_r.fault_count
                    || m_tdata[67:52] !== want_r.good_count
                    || m_tdata[71:68] !== 4'd0)
                begin
                    note_failure($sformatf({"result mismatch: expected kind %0d data %h ",
                        "off %0d st %0d seq %h src %h fault %0d good %0d; got kind %0d ",
                        "data %h off %0d st %0d seq %h src %h fault %0d good %0d pad %h"},
                        want_r.kind, want_r.data_byte, want_r.byte_offset, want_r.status,
                        want_r.sequence_res, want_r.source_address, want_r.fault_count,
                        want_r.good_count, m_tuser, m_tdata[7:0], m_tdata[16:8],
                        m_tdata[19:17], m_tdata[27:20], m_tdata[35:28], m_tdata[51:36],
                        m_tdata[67:52], m_tdata[71:68]));
                end
            end
        end
        m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // stimulus
    initial
    begin
        plan_row_t plan[$];
        int        phase_base;
        bit        long_sent;

        send_idle_pct = 24;
        recv_idle_pct = 53;

        // ignored while hunting, repeated sync, then a bad start byte
        plan.push_back(plan_row(FUNC_TICK, 8'h00, 0, 1, 0, NO_RESULT));
        plan.push_back(plan_row(FUNC_BYTE, 8'hFF, 0, 1, 0, NO_RESULT));
        plan.push_back(plan_row(FUNC_BYTE, 8'h16, 0, 1, 0, NO_RESULT));
        plan.push_back(plan_row(FUNC_BYTE, 8'h16, 0, 1, 0, NO_RESULT));
        plan.push_back(plan_row(FUNC_BYTE, 8'h00, 0, 1, 1,
            mk_res(KIND_STATUS, 8'h00, 9'd0, ST_NO_START, 8'h00, 8'h00, 16'd1, 16'd0)));
        // header with a length of nine, rejected at its crc byte
        plan.push_back(plan_row(FUNC_BYTE, 8'h16, 0, 1, 0, NO_RESULT));
        plan.push_back(plan_row(FUNC_BYTE, 8'h01, 0, 1, 0, NO_RESULT));
        plan.push_back(plan_row(FUNC_BYTE, 8'h00, 0, 1, 0, NO_RESULT));
        plan.push_back(plan_row(FUNC_BYTE, 8'h00, 0, 1, 0, NO_RESULT));
        plan.push_back(plan_row(FUNC_BYTE, 8'h00, 0, 1, 0, NO_RESULT));
        plan.push_back(plan_row(FUNC_BYTE, 8'hFF, 0, 1, 0, NO_RESULT));
        plan.push_back(plan_row(FUNC_BYTE, 8'h09, 0, 1, 0, NO_RESULT));
        plan.push_back(plan_row(FUNC_BYTE, 8'h00, 0, 1, 0, NO_RESULT));
        plan.push_back(plan_row(FUNC_BYTE, 8'h00, 1, 1, 1,
            mk_res(KIND_STATUS, 8'h00, 9'd0, ST_LENGTH, 8'h00, 8'hFF, 16'd2, 16'd0)));
        // good eleven byte packet with one command byte
        plan.push_back(plan_row(FUNC_BYTE, 8'h16, 0, 1, 0, NO_RESULT));
        plan.push_back(plan_row(FUNC_BYTE, 8'h01, 0, 1, 0, NO_RESULT));
        plan.push_back(plan_row(FUNC_BYTE, 8'h00, 0, 1, 0, NO_RESULT));
        plan.push_back(plan_row(FUNC_BYTE, 8'h00, 0, 1, 0, NO_RESULT));
        plan.push_back(plan_row(FUNC_BYTE, 8'h00, 0, 1, 0, NO_RESULT));
        plan.push_back(plan_row(FUNC_BYTE, 8'h5A, 0, 1, 0, NO_RESULT));
        plan.push_back(plan_row(FUNC_BYTE, 8'h0B, 0, 1, 0, NO_RESULT));
        plan.push_back(plan_row(FUNC_BYTE, 8'h00, 0, 1, 0, NO_RESULT));
        plan.push_back(plan_row(FUNC_BYTE, 8'h00, 1, 0, 0, NO_RESULT));
        plan.push_back(plan_row(FUNC_BYTE, 8'hFF, 0, 1, 1,
            mk_res(KIND_CMD, 8'hFF, 9'd7, ST_OK, 8'h00, 8'h5A, 16'd2, 16'd0)));
        plan.push_back(plan_row(FUNC_BYTE, 8'h80, 0, 1, 0, NO_RESULT));
        plan.push_back(plan_row(FUNC_BYTE, 8'h00, 1, 0, 0, NO_RESULT));
        plan.push_back(plan_row(FUNC_BYTE, 8'h04, 0, 1, 1,
            mk_res(KIND_STATUS, 8'h00, 9'd0, ST_OK, 8'h80, 8'h5A, 16'd2, 16'd1)));

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (plan[k])
        begin
            push_request(plan[k].func, plan[k].value, plan[k].crc_byte, plan[k].typed,
                         plan[k].typed_has, plan[k].typed_res);
        end

        // random phases, each under its own register setting; each pair shares an idling mix
        for (int p = 0; p < PHASES; p++)
        begin
            if (p > 0)
            begin
                drain_results();
                apply_config(phase_config(p));
            end
            if (p < 2)
            begin
                send_idle_pct = 24;
                recv_idle_pct = 53;
            end
            else if (p < 4)
            begin
                send_idle_pct = 53;
                recv_idle_pct = 24;
            end
            else
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            long_sent  = 1'b0;
            phase_base = counted_items;
            while (counted_items - phase_base < ITEMS_PER_PHASE)
            begin
                if (p == 4 && !long_sent)
                begin
                    send_frame(LONGEST_FRAME);
                    long_sent = 1'b1;
                end
                else if ($urandom_range(99) < 15)
                begin
                    send_noise();
                end
                else
                begin
                    send_frame(0);
                end
            end
        end

        drain_results();
        if (mismatch_count == 0 && pending_results.size() == 0)
        begin
            $display("SCOREBOARD CLEAN");
        end
        else
        begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
